// File: rtl/mandelbrot_pixel_colorizer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef MANDELBROT_PIXEL_COLORIZER_UNIT_DEFINES_SVH
`define MANDELBROT_PIXEL_COLORIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mpc_pkg.sv
// Package: shared types, constants and functions of the pixel colorizer.
package mpc_pkg;

    localparam int MAX_ITER_DEF   = 256;
    localparam int PERIOD_LEN_DEF = 20;
    localparam int FRAC_BITS      = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [30:0] RST_PIXEL_STEP   = 31'd1048576;
    localparam logic [30:0] RST_ESCAPE_BOUND = 31'd1073741824;
    localparam logic [15:0] RST_CYCLE_EPS    = 16'd16;

    localparam logic signed [63:0] QUARTER = 64'sd1 <<< (FRAC_BITS - 2);
    localparam logic signed [63:0] Q_LIMIT = (FRAC_BITS + 2 < 31) ?
        (64'sd1 <<< (FRAC_BITS + 2)) : (64'sd1 <<< 31);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_PIXEL_STEP   = 3'd2,
        REG_CENTRE_REAL  = 3'd3,
        REG_CENTRE_IMAG  = 3'd4,
        REG_ESCAPE_BOUND = 3'd5,
        REG_CYCLE_EPS    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [30:0]        pixel_step;
        logic signed [31:0] centre_real;
        logic signed [31:0] centre_imag;
        logic [30:0]        escape_bound_sq;
        logic [15:0]        cycle_epsilon;
    } mpc_cfg_t;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic               cardioid;
    } mpc_point_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } mpc_rgb_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_MAP,
        FE_CMAP,
        FE_SQ,
        FE_QSUM,
        FE_PROD,
        FE_CMP,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_RUN,
        BE_DONE
    } be_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647)
            res = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            res = 32'sh80000000;
        else
            res = v[31:0];
        return res;
    endfunction

    function automatic mpc_rgb_t palette(input int n);
        int       r;
        int       g;
        int       b;
        mpc_rgb_t c;
        if (n == 0) begin
            r = 255; g = 0; b = 0;
        end else if (n < 16) begin
            r = 16 * (16 - n); g = 0; b = 16 * n - 1;
        end else if (n < 32) begin
            r = 0; g = 16 * (n - 16); b = 16 * (32 - n) - 1;
        end else if (n < 64) begin
            r = 8 * (n - 32); g = 8 * (64 - n) - 1; b = 0;
        end else begin
            r = 255 - (n - 64) * 4; g = 0; b = 0;
            if (r < 0)
                r = 0;
        end
        c.red   = r[7:0];
        c.green = g[7:0];
        c.blue  = b[7:0];
        return c;
    endfunction

endpackage

// File: rtl/mpc_front.sv
// Front end: map a pixel to c and run the main cardioid test.
module mpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mpc_pkg::mpc_cfg_t   cfg,
    input  logic                push,
    output logic                full,
    input  logic [11:0]         pixel_x,
    input  logic [11:0]         pixel_y,
    output logic                q_push,
    input  logic                q_full,
    output mpc_pkg::mpc_point_t q_data
);

    mpc_pkg::fe_state_t state_reg, state_next;

    logic [11:0]        px_reg, py_reg;
    logic signed [45:0] prod_re_reg, prod_im_reg;
    logic signed [31:0] cre_reg, cim_reg;
    logic signed [31:0] a_reg;
    logic signed [63:0] aa_reg, ii_reg;
    logic signed [63:0] i2_reg, q_reg;
    logic signed [63:0] pq_reg;
    logic               cardioid_reg;

    logic signed [13:0] dx, dy;
    logic signed [31:0] step_s;
    logic signed [31:0] a_c;
    logic signed [33:0] q_s;
    logic signed [34:0] qa_s;
    logic signed [63:0] p4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mpc_pkg::FE_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpc_pkg::FE_IDLE: if (push) state_next = mpc_pkg::FE_MAP;
            mpc_pkg::FE_MAP:  state_next = mpc_pkg::FE_CMAP;
            mpc_pkg::FE_CMAP: state_next = mpc_pkg::FE_SQ;
            mpc_pkg::FE_SQ:   state_next = mpc_pkg::FE_QSUM;
            mpc_pkg::FE_QSUM: state_next = mpc_pkg::FE_PROD;
            mpc_pkg::FE_PROD:
                state_next = (q_reg > mpc_pkg::Q_LIMIT) ? mpc_pkg::FE_PUSH : mpc_pkg::FE_CMP;
            mpc_pkg::FE_CMP:  state_next = mpc_pkg::FE_PUSH;
            mpc_pkg::FE_PUSH: if (!q_full) state_next = mpc_pkg::FE_IDLE;
            default:          state_next = mpc_pkg::FE_IDLE;
        endcase
    end

    assign full   = (state_reg != mpc_pkg::FE_IDLE);
    assign q_push = (state_reg == mpc_pkg::FE_PUSH) && !q_full;
    assign q_data = '{c_re: cre_reg, c_im: cim_reg, cardioid: cardioid_reg};

    assign dx     = $signed({1'b0, px_reg, 1'b0}) - $signed({1'b0, cfg.image_width});
    assign dy     = $signed({1'b0, py_reg, 1'b0}) - $signed({1'b0, cfg.image_height});
    assign step_s = $signed({1'b0, cfg.pixel_step});
    assign a_c    = mpc_pkg::sat32(64'(cre_reg) - mpc_pkg::QUARTER);
    assign q_s    = q_reg[33:0];
    assign qa_s   = 35'(q_s) + 35'(a_reg);
    assign p4     = (pq_reg >>> mpc_pkg::FRAC_BITS) <<< 2;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mpc_pkg::FE_IDLE:
            begin
                px_reg <= pixel_x;
                py_reg <= pixel_y;
            end
            mpc_pkg::FE_MAP:
            begin
                prod_re_reg <= dx * step_s;
                prod_im_reg <= dy * step_s;
            end
            mpc_pkg::FE_CMAP:
            begin
                cre_reg <= mpc_pkg::sat32(64'(prod_re_reg >>> 1) + 64'(cfg.centre_real));
                cim_reg <= mpc_pkg::sat32(64'(prod_im_reg >>> 1) + 64'(cfg.centre_imag));
            end
            mpc_pkg::FE_SQ:
            begin
                a_reg  <= a_c;
                aa_reg <= a_c * a_c;
                ii_reg <= cim_reg * cim_reg;
            end
            mpc_pkg::FE_QSUM:
            begin
                i2_reg <= ii_reg >>> mpc_pkg::FRAC_BITS;
                q_reg  <= (aa_reg >>> mpc_pkg::FRAC_BITS) + (ii_reg >>> mpc_pkg::FRAC_BITS);
            end
            mpc_pkg::FE_PROD:
            begin
                cardioid_reg <= 1'b0;
                pq_reg       <= q_s * qa_s;
            end
            mpc_pkg::FE_CMP:
            begin
                cardioid_reg <= (p4 <= i2_reg);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/mpc_queue.sv
// Two-entry queue of mapped points between front end and orbit engine.
module mpc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    output logic                q_full,
    input  mpc_pkg::mpc_point_t wr_data,
    input  logic                rd,
    output logic                q_empty,
    output mpc_pkg::mpc_point_t rd_data
);

    mpc_pkg::mpc_point_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr && !rd)
                count_reg <= count_reg + 2'd1;
            else if (rd && !wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: rtl/mpc_back.sv
// Orbit engine: escape-time iteration, periodicity exit, palette and result register.
module mpc_back #(
    parameter int MAX_ITER   = mpc_pkg::MAX_ITER_DEF,
    parameter int PERIOD_LEN = mpc_pkg::PERIOD_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpc_pkg::mpc_cfg_t   cfg,
    input  logic                q_empty,
    input  mpc_pkg::mpc_point_t q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [8:0]          iteration_count,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue
);

    localparam int NW = $clog2(MAX_ITER + 1);
    localparam int PW = (PERIOD_LEN > 1) ? $clog2(PERIOD_LEN) : 1;
    localparam logic [NW-1:0] N_MAX     = NW'(MAX_ITER);
    localparam logic [PW-1:0] PHASE_END = PW'(PERIOD_LEN - 1);

    mpc_pkg::be_state_t state_reg, state_next;

    logic signed [31:0] cr_reg, ci_reg, zr_reg, zi_reg, sr_reg, si_reg;
    logic [PW-1:0]      phase_reg;
    logic [NW-1:0]      n_reg, count_reg;
    logic               out_valid_reg;
    logic [8:0]         out_count_reg;
    mpc_pkg::mpc_rgb_t  out_rgb_reg;

    logic signed [63:0] zrr, zii, zri, r2, i2;
    logic signed [31:0] zr_new, zi_new;
    logic signed [32:0] dre, dim;
    logic [32:0]        are, aim;
    logic               escaped, periodic, load_out;

    assign zrr      = zr_reg * zr_reg;
    assign zii      = zi_reg * zi_reg;
    assign zri      = zr_reg * zi_reg;
    assign r2       = zrr >>> mpc_pkg::FRAC_BITS;
    assign i2       = zii >>> mpc_pkg::FRAC_BITS;
    assign escaped  = (r2 + i2) > $signed({33'b0, cfg.escape_bound_sq});
    assign zi_new   = mpc_pkg::sat32((zri >>> (mpc_pkg::FRAC_BITS - 1)) + 64'(ci_reg));
    assign zr_new   = mpc_pkg::sat32(r2 - i2 + 64'(cr_reg));
    assign dre      = 33'(zr_new) - 33'(sr_reg);
    assign dim      = 33'(zi_new) - 33'(si_reg);
    assign are      = dre[32] ? 33'(-dre) : 33'(dre);
    assign aim      = dim[32] ? 33'(-dim) : 33'(dim);
    assign periodic = (are < {17'b0, cfg.cycle_epsilon}) && (aim < {17'b0, cfg.cycle_epsilon});

    assign load_out = (state_reg == mpc_pkg::BE_DONE) && (!out_valid_reg || pop);
    assign q_pop    = (state_reg == mpc_pkg::BE_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpc_pkg::BE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpc_pkg::BE_IDLE:
                if (!q_empty)
                    state_next = q_data.cardioid ? mpc_pkg::BE_DONE : mpc_pkg::BE_RUN;
            mpc_pkg::BE_RUN:
                if (n_reg == N_MAX || escaped || periodic)
                    state_next = mpc_pkg::BE_DONE;
            mpc_pkg::BE_DONE:
                if (!out_valid_reg || pop)
                    state_next = mpc_pkg::BE_IDLE;
            default:
                state_next = mpc_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mpc_pkg::BE_IDLE:
            begin
                cr_reg    <= q_data.c_re;
                ci_reg    <= q_data.c_im;
                zr_reg    <= q_data.c_re;
                zi_reg    <= q_data.c_im;
                sr_reg    <= '0;
                si_reg    <= '0;
                phase_reg <= '0;
                n_reg     <= '0;
                count_reg <= N_MAX;
            end
            mpc_pkg::BE_RUN:
            begin
                if (n_reg == N_MAX)
                    count_reg <= N_MAX;
                else if (escaped)
                    count_reg <= n_reg;
                else
                begin
                    zr_reg    <= zr_new;
                    zi_reg    <= zi_new;
                    count_reg <= N_MAX;
                    n_reg     <= n_reg + NW'(1);
                    if (phase_reg == PHASE_END)
                    begin
                        phase_reg <= '0;
                        sr_reg    <= zr_new;
                        si_reg    <= zi_new;
                    end
                    else
                        phase_reg <= phase_reg + PW'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_count_reg <= 9'(count_reg);
            out_rgb_reg   <= mpc_pkg::palette(int'(count_reg));
        end
    end

    assign empty           = !out_valid_reg;
    assign iteration_count = out_count_reg;
    assign red             = out_rgb_reg.red;
    assign green           = out_rgb_reg.green;
    assign blue            = out_rgb_reg.blue;

endmodule

// File: rtl/mandelbrot_pixel_colorizer_unit.sv
// Top level: Mandelbrot escape-time pixel colorizer with configuration registers.
// Usage:
//   Input queue: drive pixel_x/pixel_y with push; a request is taken when push is
//   high and full is low. full stays high while the front end maps the pixel, runs
//   the cardioid test and waits until the queue takes the point.
//   Result queue: iteration_count/red/green/blue are valid while empty is low;
//   pop takes them.
//   The orbit engine runs one complex-square iteration per cycle; a point inside the
//   cardioid skips the iteration and goes straight to the result register.
//   A two-entry queue lets the front end map the next pixels while the engine works.
//   Configuration: wr_en/wr_index/wr_data write one register per cycle; write only
//   while no request is in flight. Unknown indexes are ignored.
//   Reset: rst_n clears all queues and returns registers to their defaults.
//   Receiver stall: the finished result holds in the output register; the engine
//   waits on it, the queue fills, then full rises.
module mandelbrot_pixel_colorizer_unit #(
    parameter int MAX_ITER   = mpc_pkg::MAX_ITER_DEF,
    parameter int PERIOD_LEN = mpc_pkg::PERIOD_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [mpc_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                           push,
    output logic                           full,
    input  logic [11:0]                    pixel_x,
    input  logic [11:0]                    pixel_y,
    output logic                           empty,
    input  logic                           pop,
    output logic [8:0]                     iteration_count,
    output logic [7:0]                     red,
    output logic [7:0]                     green,
    output logic [7:0]                     blue
);

    mpc_pkg::mpc_cfg_t   cfg_reg;
    mpc_pkg::mpc_point_t fq_wr_data, fq_rd_data;
    logic                fq_wr, fq_full, fq_rd, fq_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= mpc_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height    <= mpc_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.pixel_step      <= mpc_pkg::RST_PIXEL_STEP;
            cfg_reg.centre_real     <= '0;
            cfg_reg.centre_imag     <= '0;
            cfg_reg.escape_bound_sq <= mpc_pkg::RST_ESCAPE_BOUND;
            cfg_reg.cycle_epsilon   <= mpc_pkg::RST_CYCLE_EPS;
        end
        else if (wr_en)
        begin
            case (mpc_pkg::cfg_index_t'(wr_index))
                mpc_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width     <= wr_data[12:0];
                mpc_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height    <= wr_data[12:0];
                mpc_pkg::REG_PIXEL_STEP:   cfg_reg.pixel_step      <= wr_data[30:0];
                mpc_pkg::REG_CENTRE_REAL:  cfg_reg.centre_real     <= $signed(wr_data[31:0]);
                mpc_pkg::REG_CENTRE_IMAG:  cfg_reg.centre_imag     <= $signed(wr_data[31:0]);
                mpc_pkg::REG_ESCAPE_BOUND: cfg_reg.escape_bound_sq <= wr_data[30:0];
                mpc_pkg::REG_CYCLE_EPS:    cfg_reg.cycle_epsilon   <= wr_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    mpc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .q_push  (fq_wr),
        .q_full  (fq_full),
        .q_data  (fq_wr_data)
    );

    mpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_wr),
        .q_full  (fq_full),
        .wr_data (fq_wr_data),
        .rd      (fq_rd),
        .q_empty (fq_empty),
        .rd_data (fq_rd_data)
    );

    mpc_back #(
        .MAX_ITER   (MAX_ITER),
        .PERIOD_LEN (PERIOD_LEN)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_empty         (fq_empty),
        .q_data          (fq_rd_data),
        .q_pop           (fq_rd),
        .empty           (empty),
        .pop             (pop),
        .iteration_count (iteration_count),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

endmodule

// File: rtl/mpc_checker.sv
// Port-level checker for the pixel colorizer and its bind.
`include "mandelbrot_pixel_colorizer_unit_defines.svh"

module mpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [8:0] iteration_count,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    `MPC_ASSERT_NEXT(a_busy_after_request, push && !full, full, "front end not busy after request")
    `MPC_ASSERT_NOW(a_palette_channel_zero, !empty, red == 8'd0 || green == 8'd0 || blue == 8'd0, "palette gives three nonzero channels")
    `MPC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(iteration_count), "waiting result dropped or changed")

endmodule

bind mandelbrot_pixel_colorizer_unit mpc_checker u_mpc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .iteration_count (iteration_count),
    .red             (red),
    .green           (green),
    .blue            (blue)
);

// File: dv/mandelbrot_pixel_colorizer_unit_test.sv
// Self-checking testbench for the Mandelbrot pixel colorizer: predicted pixel colors per request.
`timescale 1ns / 1ps

class pixel_color_board;
    logic [12:0]        width;
    logic [12:0]        height;
    logic [30:0]        step;
    logic signed [31:0] off_re;
    logic signed [31:0] off_im;
    logic [30:0]        bound;
    logic [15:0]        eps;
    logic [32:0]        colors_due[$];
    int                 errors;
    int                 checked;
    int                 max_hits;

    function new();
        width = 13'd640;
        height = 13'd480;
        step = 31'd1048576;
        off_re = 0;
        off_im = 0;
        bound = 31'd1073741824;
        eps = 16'd16;
        errors = 0;
        checked = 0;
        max_hits = 0;
    endfunction

    function void write_reg(mpc_pkg::cfg_index_t idx, logic [31:0] val);
        case (idx)
            mpc_pkg::REG_IMAGE_WIDTH:  width = val[12:0];
            mpc_pkg::REG_IMAGE_HEIGHT: height = val[12:0];
            mpc_pkg::REG_PIXEL_STEP:   step = val[30:0];
            mpc_pkg::REG_CENTRE_REAL:  off_re = val;
            mpc_pkg::REG_CENTRE_IMAG:  off_im = val;
            mpc_pkg::REG_ESCAPE_BOUND: bound = val[30:0];
            mpc_pkg::REG_CYCLE_EPS:    eps = val[15:0];
            default: ;
        endcase
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function longint fix_mul(longint a, longint b, int sh);
        return (a * b) >>> sh;
    endfunction

    function longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    function int orbit_count(longint cr, longint ci);
        longint a;
        longint im2;
        longint q;
        longint zr;
        longint zi;
        longint sr;
        longint si;
        longint r2;
        longint i2;
        int     phase;
        a = clamp32(cr - (64'sd1 <<< 26));
        im2 = fix_mul(ci, ci, 28);
        q = fix_mul(a, a, 28) + im2;
        if (q <= (64'sd1 <<< 30) && fix_mul(q, q + a, 28) * 4 <= im2)
            return 256;
        zr = cr;
        zi = ci;
        sr = 0;
        si = 0;
        phase = 0;
        for (int n = 0; n < 256; n++) begin
            r2 = fix_mul(zr, zr, 28);
            i2 = fix_mul(zi, zi, 28);
            if (r2 + i2 > longint'(bound))
                return n;
            zi = clamp32(fix_mul(zr, zi, 27) + ci);
            zr = clamp32(r2 - i2 + cr);
            if (labs(zr - sr) < longint'(eps) && labs(zi - si) < longint'(eps))
                return 256;
            phase++;
            if (phase == 20) begin
                phase = 0;
                sr = zr;
                si = zi;
            end
        end
        return 256;
    endfunction

    function void note_request(logic [11:0] px, logic [11:0] py);
        longint      cr;
        longint      ci;
        int          n;
        int          r;
        int          g;
        int          b;
        logic [32:0] entry;
        cr = clamp32(((2 * longint'(px) - longint'(width)) * longint'(step) >>> 1)
                     + longint'(off_re));
        ci = clamp32(((2 * longint'(py) - longint'(height)) * longint'(step) >>> 1)
                     + longint'(off_im));
        n = orbit_count(cr, ci);
        if (n == 256)
            max_hits++;
        if (n == 0) begin
            r = 255; g = 0; b = 0;
        end else if (n < 16) begin
            r = 16 * (16 - n); g = 0; b = 16 * n - 1;
        end else if (n < 32) begin
            r = 0; g = 16 * (n - 16); b = 16 * (32 - n) - 1;
        end else if (n < 64) begin
            r = 8 * (n - 32); g = 8 * (64 - n) - 1; b = 0;
        end else begin
            r = 255 - (n - 64) * 4; g = 0; b = 0;
            if (r < 0)
                r = 0;
        end
        entry = {n[8:0], r[7:0], g[7:0], b[7:0]};
        colors_due.insert(colors_due.size(), entry);
    endfunction

    function void check_color(logic [8:0] n, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [32:0] want;
        checked++;
        if (colors_due.size() == 0) begin
            $display("%0t: unexpected result %0d (%0d,%0d,%0d)", $time, n, r, g, b);
            errors++;
            return;
        end
        want = colors_due.pop_front();
        if (want[32:24] !== n) begin
            $display("%0t: count expected %0d actual %0d", $time, want[32:24], n);
            errors++;
        end
        if (want[23:16] !== r) begin
            $display("%0t: red expected %0d actual %0d", $time, want[23:16], r);
            errors++;
        end
        if (want[15:8] !== g) begin
            $display("%0t: green expected %0d actual %0d", $time, want[15:8], g);
            errors++;
        end
        if (want[7:0] !== b) begin
            $display("%0t: blue expected %0d actual %0d", $time, want[7:0], b);
            errors++;
        end
    endfunction
endclass

module mandelbrot_pixel_colorizer_unit_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [31:0] wr_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [11:0] pixel_x = '0;
    logic [11:0] pixel_y = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [8:0]  iteration_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    pixel_color_board board = new();
    int push_idle_pct = 9;
    int pop_idle_pct = 79;
    int quiet_cycles = 0;
    int requests = 0;

    mandelbrot_pixel_colorizer_unit i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && !empty && pop)
            board.check_color(iteration_count, red, green, blue);
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n)
            pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    always @(posedge clk) begin
        if (quiet_cycles > 4000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(mpc_pkg::cfg_index_t idx, logic [31:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        board.write_reg(idx, val);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_request(px, py);
        requests++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.colors_due.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic random_pixels(int count, int wide);
        for (int i = 0; i < count; i++) begin
            if (wide != 0)
                send_pixel(12'($urandom), 12'($urandom));
            else
                send_pixel(12'($urandom_range(board.width + 20)),
                           12'($urandom_range(board.height + 20)));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'hfff);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd240);
        send_pixel(12'd100, 12'd240);
        send_pixel(12'd620, 12'd240);
        send_pixel(12'd250, 12'd300);
        send_pixel(12'hfff, 12'd0);
        send_pixel(12'd0, 12'hfff);
        drain();

        write_reg(mpc_pkg::REG_IMAGE_WIDTH, 32'd64);
        write_reg(mpc_pkg::REG_IMAGE_HEIGHT, 32'd64);
        write_reg(mpc_pkg::REG_PIXEL_STEP, 32'd12582912);
        write_reg(mpc_pkg::REG_CENTRE_REAL, 32'hF8000000);
        write_reg(mpc_pkg::REG_CENTRE_IMAG, 32'd0);
        write_reg(mpc_pkg::REG_ESCAPE_BOUND, 32'd1073741824);
        write_reg(mpc_pkg::REG_CYCLE_EPS, 32'd0);
        random_pixels(350, 0);
        drain();

        push_idle_pct = 79;
        pop_idle_pct = 9;
        write_reg(mpc_pkg::REG_IMAGE_WIDTH, 32'd4096);
        write_reg(mpc_pkg::REG_IMAGE_HEIGHT, 32'd1);
        write_reg(mpc_pkg::REG_PIXEL_STEP, 32'h7fffffff);
        write_reg(mpc_pkg::REG_CENTRE_REAL, 32'h80000000);
        write_reg(mpc_pkg::REG_CENTRE_IMAG, 32'h7fffffff);
        write_reg(mpc_pkg::REG_ESCAPE_BOUND, 32'h7fffffff);
        write_reg(mpc_pkg::REG_CYCLE_EPS, 32'd65535);
        random_pixels(150, 1);
        drain();

        push_idle_pct = 0;
        pop_idle_pct = 0;
        write_reg(mpc_pkg::REG_IMAGE_WIDTH, 32'd1);
        write_reg(mpc_pkg::REG_PIXEL_STEP, 32'd1);
        write_reg(mpc_pkg::REG_CENTRE_REAL, 32'd0);
        write_reg(mpc_pkg::REG_CENTRE_IMAG, 32'd0);
        write_reg(mpc_pkg::REG_ESCAPE_BOUND, 32'd0);
        write_reg(mpc_pkg::REG_CYCLE_EPS, 32'd16);
        random_pixels(100, 1);
        drain();

        write_reg(mpc_pkg::REG_IMAGE_WIDTH, 32'd128);
        write_reg(mpc_pkg::REG_IMAGE_HEIGHT, 32'd96);
        write_reg(mpc_pkg::REG_PIXEL_STEP, 32'd6291456);
        write_reg(mpc_pkg::REG_CENTRE_REAL, 32'hF8000000);
        write_reg(mpc_pkg::REG_ESCAPE_BOUND, 32'd1073741824);
        write_reg(mpc_pkg::REG_CYCLE_EPS, 32'd256);
        for (int ph = 0; ph < 3; ph++) begin
            push_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 79 : 0;
            pop_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 9 : 0;
            random_pixels(230, 0);
        end
        drain();

        $display("Covered %0d pixel requests, %0d results checked, %0d at the iteration cap.",
                 requests, board.checked, board.max_hits);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
